### src/sicm_pkg.sv
`default_nettype none

package sicm_pkg;

  // Opcode carried on the input side band.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } sicm_state_t;

  // Command handshake from the front queue toward the store.
  typedef struct packed {
    logic valid;
    logic flush;
  } sicm_cmd_t;

  // Store status toward the top level.
  typedef struct packed {
    logic flushing;
    logic empty;
    logic full;
  } sicm_status_t;

endpackage

`default_nettype wire

### src/sorted_interval_conflict_marker.sv
// Order: with the input queue empty, a load beat passes the front queue into the store, and
//   a flush beat passes the front queue and the flush state on to the output register.
// Throughput: one load per cycle while the store is idle; a flush holds the store until
//   it is empty, one entry per cycle unless the output stalls, from the sorted chain head.
// Reset: synchronous, active high; clears the queue, the entry count, the overflow flag
//   and the output valid. Stored entries are not cleared and need no clearing pass.
`default_nettype none

module sorted_interval_conflict_marker #(
  parameter int MAX_ENTRIES = 32,
  parameter int TIME_BITS   = 16,
  parameter int TAG_BITS    = 8
) (
  input  wire logic clk,
  input  wire logic rst,

  // Input stream. tdata from bit 0: entry_tag, start_time, end_time, zero fill.
  // tuser: opcode (0 load, 1 flush).
  input  wire logic                                          s_tvalid,
  output logic                                               s_tready,
  input  wire logic [((TAG_BITS+2*TIME_BITS+7)/8)*8-1:0]     s_tdata,
  input  wire logic                                          s_tuser,

  // Output stream. tdata from bit 0: out_tag, out_start, out_end, zero fill.
  // tuser from bit 0: conflict, dropped. tlast marks the final entry of a flush.
  output logic                                               m_tvalid,
  input  wire logic                                          m_tready,
  output logic [((TAG_BITS+2*TIME_BITS+7)/8)*8-1:0]          m_tdata,
  output logic [1:0]                                         m_tuser,
  output logic                                               m_tlast
);

  localparam int DATA_W = ((TAG_BITS + 2 * TIME_BITS + 7) / 8) * 8;

  sicm_pkg::sicm_cmd_t    cmd;
  sicm_pkg::sicm_status_t status;
  logic                   cmd_ready;
  logic [TAG_BITS-1:0]    cmd_tag;
  logic [TIME_BITS-1:0]   cmd_start;
  logic [TIME_BITS-1:0]   cmd_end;
  logic [TAG_BITS-1:0]    out_tag;
  logic [TIME_BITS-1:0]   out_start;
  logic [TIME_BITS-1:0]   out_end;
  logic                   out_conflict;
  logic                   out_dropped;

  // The front takes beats into a short queue and tags each one as load or
  // flush; it holds up to two beats while the store is busy emitting.
  sicm_front #(
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS),
    .DATA_W    (DATA_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cmd_tag   (cmd_tag),
    .cmd_start (cmd_start),
    .cmd_end   (cmd_end)
  );

  // The store is a chain of compare-and-shift cells. Each cell compares the
  // new start with its own; the cells from the landing slot up shift to open
  // the slot. Overlap flags are accumulated at insert time, since overlap is
  // symmetric, so a flush only has to shift the chain out through the head.
  sicm_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready),
    .cmd_tag      (cmd_tag),
    .cmd_start    (cmd_start),
    .cmd_end      (cmd_end),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_tag      (out_tag),
    .out_start    (out_start),
    .out_end      (out_end),
    .out_conflict (out_conflict),
    .out_last     (m_tlast),
    .out_dropped  (out_dropped),
    .status       (status)
  );

  assign m_tdata = DATA_W'({out_end, out_start, out_tag});
  assign m_tuser = {out_dropped, out_conflict};

`ifndef SYNTH
  // A flush never runs on an empty store.
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    status.flushing |-> !status.empty)
    else $error("flush running with an empty store");

  // While flushing, a free output slot is refilled on the next cycle.
  a_flush_streams: assert property (@(posedge clk) disable iff (rst)
    (status.flushing && !(m_tvalid && !m_tready)) |=> m_tvalid)
    else $error("flush left the output slot empty");

  // A full store only drains through a flush.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    status.full |=> (status.full || status.flushing))
    else $error("full store lost entries outside a flush");
`endif

endmodule

`default_nettype wire

### src/sicm_front.sv
`default_nettype none

module sicm_front #(
  parameter int TIME_BITS = 16,
  parameter int TAG_BITS  = 8,
  parameter int DATA_W    = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [DATA_W-1:0]     s_tdata,
  input  wire logic                  s_tuser,
  output sicm_pkg::sicm_cmd_t        cmd,
  input  wire logic                  cmd_ready,
  output logic [TAG_BITS-1:0]        cmd_tag,
  output logic [TIME_BITS-1:0]       cmd_start,
  output logic [TIME_BITS-1:0]       cmd_end
);

  localparam int ENTRY_W = 1 + TAG_BITS + 2 * TIME_BITS;
  localparam int PTR_W   = $clog2(sicm_pkg::QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(sicm_pkg::QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] queue [sicm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] head;

  assign s_tready = (fill != FILL_W'(sicm_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign pop      = cmd.valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= {s_tuser, s_tdata[TAG_BITS+2*TIME_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(sicm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(sicm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Classify the head entry: the side band bit picks flush or load.
  assign head      = queue[rd_ptr];
  assign cmd.valid = (fill != '0);
  assign cmd.flush = (head[ENTRY_W-1] == sicm_pkg::OP_FLUSH);
  assign cmd_tag   = head[TAG_BITS-1:0];
  assign cmd_start = head[TAG_BITS+TIME_BITS-1:TAG_BITS];
  assign cmd_end   = head[TAG_BITS+2*TIME_BITS-1:TAG_BITS+TIME_BITS];

endmodule

`default_nettype wire

### src/sicm_store.sv
`default_nettype none

module sicm_store #(
  parameter int MAX_ENTRIES = 32,
  parameter int TIME_BITS   = 16,
  parameter int TAG_BITS    = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sicm_pkg::sicm_cmd_t   cmd,
  output logic                       cmd_ready,
  input  wire logic [TAG_BITS-1:0]   cmd_tag,
  input  wire logic [TIME_BITS-1:0]  cmd_start,
  input  wire logic [TIME_BITS-1:0]  cmd_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TAG_BITS-1:0]        out_tag,
  output logic [TIME_BITS-1:0]       out_start,
  output logic [TIME_BITS-1:0]       out_end,
  output logic                       out_conflict,
  output logic                       out_last,
  output logic                       out_dropped,
  output sicm_pkg::sicm_status_t     status
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Cell chain, kept sorted by start time. Entries at or above count are stale.
  logic [TAG_BITS-1:0]  c_tag   [MAX_ENTRIES];
  logic [TIME_BITS-1:0] c_start [MAX_ENTRIES];
  logic [TIME_BITS-1:0] c_end   [MAX_ENTRIES];
  logic                 c_hit   [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] lands;
  logic [MAX_ENTRIES-1:0] ovl;
  logic                   lt_head;
  logic                   new_hit;

  sicm_pkg::sicm_state_t state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic                  overflow, overflow_next;
  logic                  take;
  logic                  full;
  logic                  do_insert;
  logic                  do_emit;
  logic                  out_free;

  assign full      = (count == CNT_W'(MAX_ENTRIES));
  assign cmd_ready = (state == sicm_pkg::ST_IDLE);
  assign take      = cmd.valid && cmd_ready;
  assign do_insert = take && !cmd.flush && !full;
  assign out_free  = !out_valid || out_ready;
  assign do_emit   = (state == sicm_pkg::ST_FLUSH) && out_free;

  // Per-cell compare: does the new entry land at or below this cell, and
  // does it overlap the entry held here.
  always_comb begin
    lt_head = cmd_start < c_start[0];
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (CNT_W'(k) >= count) begin
        lands[k] = 1'b1;
        ovl[k]   = 1'b0;
      end else begin
        lands[k] = (k == 0) ? lt_head : (lt_head || (c_start[k] >= cmd_start));
        ovl[k]   = (c_start[k] < cmd_end) && (c_end[k] > cmd_start);
      end
    end
  end

  assign new_hit = |ovl;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    localparam int PREV = (k == 0) ? 0 : k - 1;
    localparam int NEXT = (k == MAX_ENTRIES - 1) ? k : k + 1;
    logic first;
    assign first = (k == 0) || !lands[PREV];

    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (lands[k] && first) begin
          c_tag[k]   <= cmd_tag;
          c_start[k] <= cmd_start;
          c_end[k]   <= cmd_end;
          c_hit[k]   <= new_hit;
        end else if (lands[k]) begin
          c_tag[k]   <= c_tag[PREV];
          c_start[k] <= c_start[PREV];
          c_end[k]   <= c_end[PREV];
          c_hit[k]   <= c_hit[PREV] || ovl[PREV];
        end else begin
          c_hit[k]   <= c_hit[k] || ovl[k];
        end
      end else if (do_emit) begin
        c_tag[k]   <= c_tag[NEXT];
        c_start[k] <= c_start[NEXT];
        c_end[k]   <= c_end[NEXT];
        c_hit[k]   <= c_hit[NEXT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sicm_pkg::ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    unique case (state)
      sicm_pkg::ST_IDLE: begin
        if (take) begin
          if (cmd.flush) begin
            if (count == '0) begin
              overflow_next = 1'b0;
            end else begin
              state_next = sicm_pkg::ST_FLUSH;
            end
          end else if (full) begin
            overflow_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      sicm_pkg::ST_FLUSH: begin
        if (out_free) begin
          count_next = count - 1'b1;
          if (count == CNT_W'(1)) begin
            state_next    = sicm_pkg::ST_IDLE;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = sicm_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: the head cell moves here, the chain shifts down.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_tag      <= c_tag[0];
      out_start    <= c_start[0];
      out_end      <= c_end[0];
      out_conflict <= c_hit[0];
      out_last     <= (count == CNT_W'(1));
      out_dropped  <= overflow;
    end
  end

  assign status.flushing = (state == sicm_pkg::ST_FLUSH);
  assign status.empty    = (count == '0);
  assign status.full     = full;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS    = 32;
  localparam int TAG_W    = 8;
  localparam int TIME_W   = 16;
  localparam int DATA_W   = ((TAG_W + 2 * TIME_W + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 80;

  // One command for the block: a load of one interval or a flush.
  // When wait_drain is set, the command is held back until every
  // expected result beat has been received.
  typedef struct {
    logic              op;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    bit                wait_drain;
  } interval_cmd_t;

  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
  } interval_t;

  typedef struct {
    interval_t span;
    logic      conflict;
    logic      last;
    logic      dropped;
  } flush_beat_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tuser = sicm_pkg::OP_LOAD;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;

  sorted_interval_conflict_marker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Commands waiting to be sent, filled once at time zero.
  interval_cmd_t cmd_queue[$];

  // Our own copy of the sorted store and the beats a flush must produce.
  interval_t   sorted_spans[SLOTS];
  int          span_count = 0;
  bit          overflow_flag = 1'b0;
  flush_beat_t flush_beats_due[$];

  // Written by the monitor only; tells the driver that nothing is outstanding.
  logic drained = 1'b1;
  // Idle pattern: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
  logic [1:0] idle_phase = 2'd0;
  int beats_sent = 0;

  int fail_count = 0;
  int loads_seen = 0;
  int flushes_seen = 0;
  int loads_dropped = 0;
  int beats_checked = 0;
  int conflicts_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: sorted insert with the first-entry quirk, and the overlap scan.
  // ---------------------------------------------------------------------------

  function automatic void insert_span(logic [TAG_W-1:0] tag, logic [TIME_W-1:0] t_start,
                                      logic [TIME_W-1:0] t_end);
    int pos;
    int k;
    loads_seen++;
    if (span_count >= SLOTS) begin
      // A full store drops the load and remembers it until the next flush.
      overflow_flag = 1'b1;
      loads_dropped++;
      return;
    end
    // The first entry is compared alone; past it, a new entry lands in front of
    // any entries that share its start time.
    if (span_count == 0 || t_start < sorted_spans[0].t_start) begin
      pos = 0;
    end else begin
      pos = 1;
      while (pos < span_count && sorted_spans[pos].t_start < t_start) pos++;
    end
    for (k = span_count; k > pos; k--) sorted_spans[k] = sorted_spans[k-1];
    sorted_spans[pos].tag     = tag;
    sorted_spans[pos].t_start = t_start;
    sorted_spans[pos].t_end   = t_end;
    span_count++;
  endfunction

  function automatic void flush_spans();
    flush_beat_t beat;
    int i;
    int j;
    flushes_seen++;
    for (i = 0; i < span_count; i++) begin
      beat.span     = sorted_spans[i];
      beat.conflict = 1'b0;
      // Half-open overlap, taken as written even when the end is not above the start.
      for (j = 0; j < span_count; j++) begin
        if (j != i && sorted_spans[i].t_start < sorted_spans[j].t_end &&
            sorted_spans[i].t_end > sorted_spans[j].t_start) beat.conflict = 1'b1;
      end
      beat.last    = (i == span_count - 1);
      beat.dropped = overflow_flag;
      flush_beats_due.push_back(beat);
    end
    span_count    = 0;
    overflow_flag = 1'b0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 50) $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the head of the command queue, idles by phase, and holds
  // a draining command back until the result side is empty.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : driver_proc
    logic taken;
    logic present;
    int   gap_pct;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      taken = s_tvalid && s_tready;
      if (taken) begin
        void'(cmd_queue.pop_front());
        beats_sent++;
        idle_phase <= 2'((beats_sent / 16) % 4);
      end
      if (!s_tvalid || taken) begin
        gap_pct = (idle_phase == 2'd1) ? 79 : (idle_phase == 2'd3) ? 23 : 0;
        present = (cmd_queue.size() != 0);
        // The drain flag is registered, so a beat taken right now blocks the hold-off too.
        if (present && cmd_queue[0].wait_drain && (taken || !drained)) present = 1'b0;
        if (present && $urandom_range(0, 99) < gap_pct) present = 1'b0;
        s_tvalid <= present;
        if (present) begin
          s_tdata <= {cmd_queue[0].t_end, cmd_queue[0].t_start, cmd_queue[0].tag};
          s_tuser <= cmd_queue[0].op;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: feeds accepted input beats to the predictor and checks each
  // accepted output beat against the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor_proc
    flush_beat_t want;
    int          stall_pct;
    if (rst) begin
      m_tready <= 1'b0;
      drained  <= 1'b1;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == sicm_pkg::OP_FLUSH) flush_spans();
        else insert_span(s_tdata[TAG_W-1:0], s_tdata[TAG_W+TIME_W-1:TAG_W],
                         s_tdata[TAG_W+2*TIME_W-1:TAG_W+TIME_W]);
      end
      if (m_tvalid && m_tready) begin
        if (flush_beats_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 50)
            $display("%0t: expected no beat, got tag %0d start %0d end %0d", $time,
                     m_tdata[TAG_W-1:0], m_tdata[TAG_W+TIME_W-1:TAG_W],
                     m_tdata[TAG_W+2*TIME_W-1:TAG_W+TIME_W]);
        end else begin
          want = flush_beats_due.pop_front();
          beats_checked++;
          if (want.conflict) conflicts_seen++;
          check_field("tag", want.span.tag, m_tdata[TAG_W-1:0]);
          check_field("start", want.span.t_start, m_tdata[TAG_W+TIME_W-1:TAG_W]);
          check_field("end", want.span.t_end, m_tdata[TAG_W+2*TIME_W-1:TAG_W+TIME_W]);
          check_field("conflict", want.conflict, m_tuser[0]);
          check_field("dropped", want.dropped, m_tuser[1]);
          check_field("last", want.last, m_tlast);
        end
      end
      drained   <= (flush_beats_due.size() == 0);
      stall_pct = (idle_phase == 2'd2) ? 79 : (idle_phase == 2'd3) ? 23 : 0;
      m_tready  <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: a long stretch with no beat on either side means the block hung.
  always @(posedge clk) begin : watchdog_proc
    int quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_cmd(logic op, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] t_start,
                          logic [TIME_W-1:0] t_end, bit wait_drain);
    interval_cmd_t cmd;
    cmd.op         = op;
    cmd.tag        = tag;
    cmd.t_start    = t_start;
    cmd.t_end      = t_end;
    cmd.wait_drain = wait_drain;
    cmd_queue.push_back(cmd);
  endtask

  // Start times cluster in a few windows so that overlaps and equal starts
  // turn up often, with full-range values mixed in.
  function automatic logic [TIME_W-1:0] pick_start();
    case ($urandom_range(0, 3))
      0: return TIME_W'($urandom);
      1: return TIME_W'($urandom_range(0, 255));
      2: return TIME_W'(65535 - $urandom_range(0, 255));
      default: return TIME_W'($urandom_range(1000, 1400));
    endcase
  endfunction

  task automatic push_random_load(bit wait_drain);
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    t_start = pick_start();
    // Mostly a short interval after the start; it may wrap, and sometimes the end is arbitrary.
    if ($urandom_range(0, 3) != 0) t_end = t_start + TIME_W'($urandom_range(1, 300));
    else t_end = TIME_W'($urandom);
    push_cmd(sicm_pkg::OP_LOAD, TAG_W'($urandom), t_start, t_end, wait_drain);
  endtask

  initial begin : stimulus
    int  made;
    int  run_len;
    int  k;
    bit  long_run_done;
    bit  hold;

    // Directed: an empty flush, then the field extremes with an end at or below
    // its start, then the ordering rules around the first entry.
    push_cmd(sicm_pkg::OP_FLUSH, 8'h00, 16'h0000, 16'h0000, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h00, 16'h0000, 16'h0000, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'hA5, 16'd100,  16'd200,  1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h11, 16'h0000, 16'd10,   1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h22, 16'd50,   16'h0000, 1'b0);
    push_cmd(sicm_pkg::OP_FLUSH, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h01, 16'd1000, 16'd2000, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h02, 16'd500,  16'd600,  1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h03, 16'd500,  16'd900,  1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h04, 16'd800,  16'd1500, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h05, 16'd800,  16'd850,  1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h06, 16'hFFFF, 16'h0000, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h5A, 16'd300,  16'hFFFF, 1'b0);
    push_cmd(sicm_pkg::OP_LOAD,  8'h07, 16'd2000, 16'd2100, 1'b0);
    push_cmd(sicm_pkg::OP_FLUSH, 8'h00, 16'h0000, 16'h0000, 1'b0);
    // A flush right after a flush emits nothing.
    push_cmd(sicm_pkg::OP_FLUSH, 8'h00, 16'h0000, 16'h0000, 1'b1);

    // Random: runs of loads closed by a flush. One run is guaranteed to overfill
    // the store; most others stay small. Some runs start only once all results are in.
    made          = 0;
    long_run_done = 1'b0;
    hold          = 1'b1;
    while (made < RANDOM_ITEMS) begin
      if ((!long_run_done && made >= 30) || $urandom_range(0, 11) == 0) begin
        run_len       = $urandom_range(SLOTS + 1, SLOTS + 4);
        long_run_done = 1'b1;
      end else begin
        run_len = $urandom_range(0, 8);
      end
      for (k = 0; k < run_len; k++) begin
        push_random_load(hold);
        hold = 1'b0;
        made++;
      end
      push_cmd(sicm_pkg::OP_FLUSH, TAG_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
               hold);
      made++;
      hold = ($urandom_range(0, 3) == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (cmd_queue.size() != 0 || s_tvalid || flush_beats_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d loads (%0d dropped on a full store) and %0d flushes.",
             loads_seen, loads_dropped, flushes_seen);
    $display("Checked %0d result beats, %0d of them marked as overlapping.",
             beats_checked, conflicts_seen);
    if (fail_count == 0 && flush_beats_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
src/sicm_pkg.sv
src/sicm_front.sv
src/sicm_store.sv
src/sorted_interval_conflict_marker.sv
dv/testbench.sv
